// ----- src/mfhd_pkg.sv -----
`default_nettype none
package mfhd_pkg;

    // Stream and field widths
    localparam int unsigned ByteW = 8;
    localparam int unsigned EventW = 3;
    localparam int unsigned LenW = 28;
    localparam int unsigned MaskW = 16;
    localparam int unsigned NibW = 4;

    // Remaining-length encoding
    localparam int unsigned MaxLengthBytes = 4;
    localparam int unsigned LenGroupBits = 7;
    localparam int unsigned LenCountW = 3;
    localparam int unsigned ShiftW = 5;

    // Queue between the parser and the output stage
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW = 2;
    localparam int unsigned QueueCntW = 3;

    // Register map
    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;
    localparam logic RegPassMask = 1'b0;
    localparam logic RegSwallowMask = 1'b1;
    localparam logic [MaskW-1:0] PassMaskReset = 16'h2208;
    localparam logic [MaskW-1:0] SwallowMaskReset = 16'h0800;

    // Event codes
    localparam logic [EventW-1:0] EvHeader = 3'd0;
    localparam logic [EventW-1:0] EvData = 3'd1;
    localparam logic [EventW-1:0] EvSwallowed = 3'd2;
    localparam logic [EventW-1:0] EvBadType = 3'd3;
    localparam logic [EventW-1:0] EvError = 3'd4;

    // Output tdata width: event, type, length, data byte, padded to bytes
    localparam int unsigned OutFieldsW = EventW + ByteW + LenW + ByteW;
    localparam int unsigned OutDataW = ((OutFieldsW + 7) / 8) * 8;

    typedef struct packed {
        logic [EventW-1:0] event_res;
        logic [ByteW-1:0]  packet_type;
        logic [LenW-1:0]   remaining_length;
        logic [ByteW-1:0]  data_byte;
        logic              last;
    } mfhd_item_t;

    typedef struct packed {
        logic [MaskW-1:0] pass_type_mask;
        logic [MaskW-1:0] swallow_type_mask;
    } mfhd_cfg_t;

endpackage
`default_nettype wire

// ----- src/mfhd_front.sv -----
`default_nettype none
module mfhd_front
    import mfhd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [ByteW-1:0] rx_byte,
    input  wire logic             read_failed,
    input  wire mfhd_cfg_t        cfg,
    output logic                  push_valid,
    output mfhd_item_t            push_item
);

    localparam logic [1:0] PhType = 2'd0;
    localparam logic [1:0] PhLen = 2'd1;
    localparam logic [1:0] PhPayload = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [ByteW-1:0]     type_reg, type_next;
    logic [LenW-1:0]      acc_reg, acc_next;
    logic [LenCountW-1:0] cnt_reg, cnt_next;
    logic [LenW-1:0]      left_reg, left_next;
    logic                 swl_reg, swl_next;

    logic [ShiftW-1:0]    shamt;
    logic [LenW-1:0]      acc_sum;
    logic [LenW-1:0]      left_dec;
    logic [NibW-1:0]      nib;

    // Length group placement and payload countdown
    assign shamt = ShiftW'(LenGroupBits * cnt_reg);
    assign acc_sum = acc_reg + (LenW'(rx_byte[LenGroupBits-1:0]) << shamt);
    assign left_dec = left_reg - LenW'(1);
    assign nib = type_reg[ByteW-1 -: NibW];

    // Parse one transaction and classify the packet
    always_comb begin
        phase_next = phase_reg;
        type_next = type_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        left_next = left_reg;
        swl_next = swl_reg;
        push_valid = 1'b0;
        push_item = '0;
        if (in_accept) begin
            if (read_failed || phase_reg > PhPayload) begin
                phase_next = PhType;
                acc_next = '0;
                cnt_next = '0;
                left_next = '0;
                swl_next = 1'b0;
                push_valid = 1'b1;
                push_item.event_res = EvError;
                push_item.last = 1'b1;
            end else begin
                case (phase_reg)
                    PhType: begin
                        type_next = rx_byte;
                        acc_next = '0;
                        cnt_next = '0;
                        phase_next = PhLen;
                    end
                    PhLen: begin
                        if (cnt_reg >= LenCountW'(MaxLengthBytes)) begin
                            phase_next = PhType;
                            acc_next = '0;
                            cnt_next = '0;
                            left_next = '0;
                            swl_next = 1'b0;
                            push_valid = 1'b1;
                            push_item.event_res = EvError;
                            push_item.last = 1'b1;
                        end else begin
                            acc_next = acc_sum;
                            cnt_next = cnt_reg + LenCountW'(1);
                            if (!rx_byte[ByteW-1]) begin
                                push_item.packet_type = type_reg;
                                if (cfg.pass_type_mask[nib]) begin
                                    push_valid = 1'b1;
                                    push_item.event_res = EvHeader;
                                    if (acc_sum == '0) begin
                                        push_item.last = 1'b1;
                                        phase_next = PhType;
                                        acc_next = '0;
                                        cnt_next = '0;
                                        left_next = '0;
                                        swl_next = 1'b0;
                                    end else begin
                                        push_item.remaining_length = acc_sum;
                                        phase_next = PhPayload;
                                        swl_next = 1'b0;
                                        left_next = acc_sum;
                                    end
                                end else if (cfg.swallow_type_mask[nib]) begin
                                    if (acc_sum == '0) begin
                                        push_valid = 1'b1;
                                        push_item.event_res = EvSwallowed;
                                        push_item.last = 1'b1;
                                        phase_next = PhType;
                                        acc_next = '0;
                                        cnt_next = '0;
                                        left_next = '0;
                                        swl_next = 1'b0;
                                    end else begin
                                        phase_next = PhPayload;
                                        swl_next = 1'b1;
                                        left_next = acc_sum;
                                    end
                                end else begin
                                    push_valid = 1'b1;
                                    push_item.event_res = EvBadType;
                                    push_item.remaining_length = acc_sum;
                                    push_item.last = 1'b1;
                                    phase_next = PhType;
                                    acc_next = '0;
                                    cnt_next = '0;
                                    left_next = '0;
                                    swl_next = 1'b0;
                                end
                            end
                        end
                    end
                    default: begin
                        // Payload: count down, forward or drop
                        left_next = left_dec;
                        push_item.packet_type = type_reg;
                        push_item.remaining_length = acc_reg;
                        if (left_dec == '0) begin
                            push_valid = 1'b1;
                            push_item.last = 1'b1;
                            push_item.event_res = swl_reg ? EvSwallowed : EvData;
                            push_item.data_byte = swl_reg ? '0 : rx_byte;
                            phase_next = PhType;
                            acc_next = '0;
                            cnt_next = '0;
                            swl_next = 1'b0;
                        end else if (!swl_reg) begin
                            push_valid = 1'b1;
                            push_item.event_res = EvData;
                            push_item.data_byte = rx_byte;
                        end
                    end
                endcase
            end
        end
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PhType;
            type_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            left_reg <= '0;
            swl_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            type_reg <= type_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            left_reg <= left_next;
            swl_reg <= swl_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/mfhd_queue.sv -----
`default_nettype none
module mfhd_queue
    import mfhd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire mfhd_item_t push_item,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output mfhd_item_t      head
);

    mfhd_item_t           mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full = (cnt_reg == QueueCntW'(QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QueuePtrW'(1) : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QueueCntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QueueCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- src/mfhd_back.sv -----
`default_nettype none
module mfhd_back
    import mfhd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_not_empty,
    input  wire mfhd_item_t        q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OutDataW-1:0]    m_tdata,
    output logic                   m_tlast
);

    logic       valid_reg, valid_next;
    mfhd_item_t item_reg;

    // Load the output register when it is empty or being taken
    assign q_pop = q_not_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
        end
    end

    // Pack fields, event in the lowest bits
    assign m_tvalid = valid_reg;
    assign m_tlast = item_reg.last;
    assign m_tdata = OutDataW'({item_reg.data_byte, item_reg.remaining_length,
                                item_reg.packet_type, item_reg.event_res});

endmodule
`default_nettype wire

// ----- src/mqtt_fixed_header_deframer_top.sv -----
// Path: the parser writes a byte's result into the queue when the byte is accepted, and
//   the output register then loads it from the queue and drives m_tvalid.
// Throughput: one byte per cycle while the queue is not full; the four-entry queue and output register
//   let the input keep accepting while a result waits on m_tready.
// Reset: synchronous active-low aresetn returns the parser to the type byte,
//   empties the queue and output, and loads the mask registers' defaults.
`default_nettype none
module mqtt_fixed_header_deframer_top
    import mfhd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [ByteW-1:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]          s_tuser,   // [0] read_failed
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutDataW-1:0]      m_tdata,   // [2:0] event_res, [10:3] packet_type,
                                                // [38:11] remaining_length,
                                                // [46:39] data_byte, [47] zero
    output logic                     m_tlast,   // last
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [AddrW-1:0]    paddr,
    input  wire logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]         prdata,
    output logic                     pready
);

    mfhd_cfg_t  cfg_reg;
    logic       cfg_wr;
    logic       in_accept;
    logic       push_valid;
    mfhd_item_t push_item;
    logic       q_full, q_not_empty, q_pop;
    mfhd_item_t q_head;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pass_type_mask <= PassMaskReset;
            cfg_reg.swallow_type_mask <= SwallowMaskReset;
        end else if (cfg_wr) begin
            if (paddr[2] == RegPassMask) begin
                cfg_reg.pass_type_mask <= pwdata[MaskW-1:0];
            end else begin
                cfg_reg.swallow_type_mask <= pwdata[MaskW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == RegSwallowMask) begin
            prdata = DataW'(cfg_reg.swallow_type_mask);
        end else begin
            prdata = DataW'(cfg_reg.pass_type_mask);
        end
    end

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign in_accept = s_tvalid && s_tready;

    mfhd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_tdata),
        .read_failed (s_tuser[0]),
        .cfg         (cfg_reg),
        .push_valid  (push_valid),
        .push_item   (push_item)
    );

    mfhd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mfhd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire
